FILE: rtl/best_fit_block_allocator_top_defines.svh
// assertion macros for the best-fit block allocator
`ifndef BEST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising edge, off during reset
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bfa_pkg.sv
// shared constants and codes for the best-fit block allocator
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int DEF_NUM_BLOCKS = 1024;
  localparam int DEF_BLOCK_SIZE = 64;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // dividend width: a full request plus the rounding term needs 33 bits
  localparam int DIV_W   = 33;

endpackage

FILE: rtl/best_fit_block_allocator_top.sv
// best-fit boundary-tag block allocator: reciprocal divide, tag walk and merge sequencer
// items: one at a time; a new item is taken in idle only, once the last result has been issued
// reset: a clearing pass writes every entry of the tag memory before the first item
// reset: base address goes to zero; configuration writes are taken at any time
`timescale 1ns / 1ps
`include "best_fit_block_allocator_top_defines.svh"

module best_fit_block_allocator_top #(
  parameter int NUM_BLOCKS = bfa_pkg::DEF_NUM_BLOCKS,
  parameter int BLOCK_SIZE = bfa_pkg::DEF_BLOCK_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [31:0] request_bytes,
  input  logic [31:0] free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [31:0] block_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] base_address
);
  import bfa_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int TW = $clog2(NUM_BLOCKS + 1) + 1;
  localparam int XW = $clog2(NUM_BLOCKS + 1) + 3;
  // reciprocal divide: exact for every dividend below 2^NW
  localparam int NW = $clog2((NUM_BLOCKS + 1) * BLOCK_SIZE);
  localparam int LW = $clog2(BLOCK_SIZE);
  localparam int SH = NW + LW;
  localparam int MW = NW + 2;
  localparam int QW = NW + 2 - LW;
  localparam int PW = NW + MW;
  localparam longint RECIP_L = ((longint'(1) << SH) + longint'(BLOCK_SIZE - 1))
                               / longint'(BLOCK_SIZE);
  localparam logic [MW-1:0]    RECIP     = MW'(RECIP_L);
  localparam logic [DIV_W-1:0] BS_Q      = DIV_W'(BLOCK_SIZE);
  localparam logic [DIV_W-1:0] LIM_FREE  = DIV_W'(NUM_BLOCKS * BLOCK_SIZE);
  localparam logic [DIV_W-1:0] LIM_ALLOC = DIV_W'((NUM_BLOCKS + 1) * BLOCK_SIZE);
  localparam logic signed [XW-1:0] N_X   = XW'(NUM_BLOCKS);
  localparam logic signed [XW-1:0] ONE_X = XW'(1);
  localparam logic signed [XW-1:0] ZERO_X = '0;
  localparam logic [31:0]      BS_32 = 32'(BLOCK_SIZE);
  localparam logic [AW-1:0]    LAST_A = AW'(NUM_BLOCKS - 1);
  localparam int NS = 27;

  typedef enum logic [NS-1:0] {
    S_CLEAR = NS'(1) << 0,
    S_IDLE  = NS'(1) << 1,
    S_DIV   = NS'(1) << 2,
    S_QCHK  = NS'(1) << 3,
    S_W_RD  = NS'(1) << 4,
    S_W_EV  = NS'(1) << 5,
    S_A_CHK = NS'(1) << 6,
    S_A_W1  = NS'(1) << 7,
    S_A_W2  = NS'(1) << 8,
    S_A_W3  = NS'(1) << 9,
    S_A_W4  = NS'(1) << 10,
    S_MUL   = NS'(1) << 11,
    S_F_RD  = NS'(1) << 12,
    S_F_EV  = NS'(1) << 13,
    S_F_W1  = NS'(1) << 14,
    S_F_W2  = NS'(1) << 15,
    S_M_RD1 = NS'(1) << 16,
    S_M_EV1 = NS'(1) << 17,
    S_M_RD2 = NS'(1) << 18,
    S_M_EV2 = NS'(1) << 19,
    S_M_W1  = NS'(1) << 20,
    S_M_W2  = NS'(1) << 21,
    S_M_W3  = NS'(1) << 22,
    S_M_W4  = NS'(1) << 23,
    S_P_RD  = NS'(1) << 24,
    S_P_EV  = NS'(1) << 25,
    S_FIN   = NS'(1) << 26
  } state_t;

  state_t state;

  // tag memory, undefined at power-up, swept by the clearing pass
  logic signed [TW-1:0] tag_mem [NUM_BLOCKS];
  logic signed [TW-1:0] rd_data;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic signed [TW-1:0] mem_wdata;
  logic signed [XW-1:0] widx;
  logic signed [XW-1:0] wval;
  logic signed [XW-1:0] ridx;
  logic                 wr_state;

  logic [AW-1:0]        clr_cnt;
  logic [31:0]          heap_base;

  // divide by the block size
  logic [DIV_W-1:0]     div_num;
  logic [QW-1:0]        div_quo;
  logic [PW-1:0]        div_prod;

  // item context
  logic                 is_free;
  logic                 res_fail;
  logic                 addr_ok;
  logic signed [XW-1:0] want;
  logic signed [XW-1:0] walk_idx;
  logic signed [XW-1:0] best;
  logic signed [XW-1:0] best_len;
  logic                 have_best;
  logic signed [XW-1:0] at;
  logic signed [XW-1:0] m_at;
  logic signed [XW-1:0] m_len;
  logic signed [XW-1:0] m_joined;
  logic                 pass2;
  logic [31:0]          prod;

  // walk and merge arithmetic on the tag just read
  logic signed [XW-1:0] t_x;
  logic signed [XW-1:0] step;
  logic signed [XW-1:0] walk_next;
  logic                 fits;
  logic                 take;
  logic signed [XW-1:0] joined;
  state_t               merge_done;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign t_x       = XW'(rd_data);
  assign fits      = (t_x >= want);
  assign take      = fits && (!have_best || (t_x < best_len));
  assign walk_next = walk_idx + step;
  assign joined    = m_len + t_x;
  assign merge_done = pass2 ? S_FIN : ((at > ZERO_X) ? S_P_RD : S_FIN);

  always_comb begin
    if (t_x < ZERO_X) begin
      step = -t_x;
    end else if (t_x == ZERO_X) begin
      step = ONE_X;
    end else begin
      step = t_x;
    end
  end

  assign div_prod = PW'(div_num[NW-1:0]) * PW'(RECIP);

  // memory address and data selection per sequencer step
  always_comb begin
    widx     = ZERO_X;
    wval     = ZERO_X;
    ridx     = ZERO_X;
    wr_state = 1'b0;
    mem_re   = 1'b0;
    unique case (state)
      S_A_W1: begin
        wr_state = 1'b1;
        widx     = best + want;
        wval     = best_len - want;
      end
      S_A_W2: begin
        wr_state = 1'b1;
        widx     = best + best_len - ONE_X;
        wval     = best_len - want;
      end
      S_A_W3: begin
        wr_state = 1'b1;
        widx     = best;
        wval     = -want;
      end
      S_A_W4: begin
        wr_state = 1'b1;
        widx     = best + want - ONE_X;
        wval     = -want;
      end
      S_F_W1: begin
        wr_state = 1'b1;
        widx     = at;
        wval     = m_len;
      end
      S_F_W2: begin
        wr_state = 1'b1;
        widx     = at + m_len - ONE_X;
        wval     = m_len;
      end
      S_M_W1: begin
        wr_state = 1'b1;
        widx     = m_at + m_len - ONE_X;
      end
      S_M_W2: begin
        wr_state = 1'b1;
        widx     = m_at + m_len;
      end
      S_M_W3: begin
        wr_state = 1'b1;
        widx     = m_at;
        wval     = m_joined;
      end
      S_M_W4: begin
        wr_state = 1'b1;
        widx     = m_at + m_joined - ONE_X;
        wval     = m_joined;
      end
      S_W_RD: begin
        mem_re = 1'b1;
        ridx   = walk_idx;
      end
      S_F_RD: begin
        mem_re = 1'b1;
        ridx   = at;
      end
      S_M_RD1: begin
        mem_re = 1'b1;
        ridx   = m_at;
      end
      S_M_RD2: begin
        mem_re = 1'b1;
        ridx   = m_at + m_len;
      end
      S_P_RD: begin
        mem_re = 1'b1;
        ridx   = at - ONE_X;
      end
      default: begin
      end
    endcase

    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = ((clr_cnt == '0) || (clr_cnt == LAST_A)) ? TW'(NUM_BLOCKS) : '0;
    end else begin
      // writes that fall outside the map are dropped
      mem_we    = wr_state && (widx >= ZERO_X) && (widx < N_X);
      mem_waddr = widx[AW-1:0];
      mem_wdata = TW'(wval);
    end
    mem_raddr = ridx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= tag_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
    end else if (cfg_valid) begin
      heap_base <= base_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_A) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            is_free  <= (operation == OP_FREE);
            res_fail <= 1'b0;
            addr_ok  <= 1'b0;
            if (operation == OP_FREE) begin
              div_num <= DIV_W'(free_address - heap_base);
              if (free_address < heap_base) begin
                res_fail <= 1'b1;
                state    <= S_FIN;
              end else begin
                state <= S_DIV;
              end
            end else begin
              // round up to whole blocks
              div_num <= DIV_W'(request_bytes) + DIV_W'(BLOCK_SIZE - 1);
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          div_quo <= div_prod[SH +: QW];
          state   <= S_QCHK;
        end
        S_QCHK: begin
          want      <= signed'(XW'(div_quo));
          at        <= signed'(XW'(div_quo));
          walk_idx  <= ZERO_X;
          have_best <= 1'b0;
          pass2     <= 1'b0;
          // range checks on the dividend keep the quotient exact
          if (is_free) begin
            if (div_num >= LIM_FREE) begin
              res_fail <= 1'b1;
              state    <= S_FIN;
            end else begin
              state <= S_F_RD;
            end
          end else if ((div_num < BS_Q) || (div_num >= LIM_ALLOC)) begin
            res_fail <= 1'b1;
            state    <= S_FIN;
          end else begin
            state <= S_W_RD;
          end
        end
        S_W_RD: begin
          state <= S_W_EV;
        end
        S_W_EV: begin
          if (take) begin
            best      <= walk_idx;
            best_len  <= t_x;
            have_best <= 1'b1;
          end
          walk_idx <= walk_next;
          // an exact fit ends the walk early
          if ((fits && (t_x == want)) || (walk_next >= N_X)) begin
            state <= S_A_CHK;
          end else begin
            state <= S_W_RD;
          end
        end
        S_A_CHK: begin
          if (!have_best) begin
            res_fail <= 1'b1;
            state    <= S_FIN;
          end else if (best_len > want) begin
            state <= S_A_W1;
          end else begin
            state <= S_A_W3;
          end
        end
        S_A_W1: state <= S_A_W2;
        S_A_W2: state <= S_A_W3;
        S_A_W3: state <= S_A_W4;
        S_A_W4: state <= S_MUL;
        S_MUL: begin
          prod    <= 32'(best[AW-1:0]) * BS_32;
          addr_ok <= 1'b1;
          state   <= S_FIN;
        end
        S_F_RD: begin
          state <= S_F_EV;
        end
        S_F_EV: begin
          m_len <= -t_x;
          // only a used tag may be freed, and the segment must stay inside the map
          if ((t_x >= ZERO_X) || ((at - t_x) > N_X)) begin
            res_fail <= 1'b1;
            state    <= S_FIN;
          end else begin
            state <= S_F_W1;
          end
        end
        S_F_W1: state <= S_F_W2;
        S_F_W2: begin
          m_at  <= at;
          state <= S_M_RD1;
        end
        S_M_RD1: begin
          state <= S_M_EV1;
        end
        S_M_EV1: begin
          m_len <= t_x;
          if ((t_x <= ZERO_X) || ((m_at + t_x) >= N_X)) begin
            state <= merge_done;
          end else begin
            state <= S_M_RD2;
          end
        end
        S_M_RD2: begin
          state <= S_M_EV2;
        end
        S_M_EV2: begin
          m_joined <= joined;
          if ((t_x <= ZERO_X) || ((m_at + joined) > N_X)) begin
            state <= merge_done;
          end else begin
            state <= S_M_W1;
          end
        end
        S_M_W1: state <= S_M_W2;
        S_M_W2: state <= S_M_W3;
        S_M_W3: state <= S_M_W4;
        S_M_W4: state <= merge_done;
        S_P_RD: begin
          state <= S_P_EV;
        end
        S_P_EV: begin
          // a free segment just below: merge from its start
          if (t_x > ZERO_X) begin
            m_at  <= at - t_x;
            pass2 <= 1'b1;
            if ((at - t_x) < ZERO_X) begin
              state <= S_FIN;
            end else begin
              state <= S_M_RD1;
            end
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_fail ? STATUS_FAIL : STATUS_OK;
            block_address <= addr_ok ? (heap_base + prod) : '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BFA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready held after accept")
  `BFA_ASSERT_NOW(a_fail_zero_addr, out_valid && (status == STATUS_FAIL), block_address == '0, "failed item has address")
  `BFA_ASSERT_NOW(a_best_fits, (state == S_W_RD) && have_best, best_len >= want, "best segment too small")

endmodule
